// File: sv/i2cmts_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
package i2cmts_pkg;

  // Default width of the byte counter.
  localparam int unsigned LEN_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_FIRST_LENGTH  = 2'd1;
  localparam logic [1:0] REG_FOLLOW_MODE   = 2'd2;
  localparam logic [1:0] REG_SECOND_LENGTH = 2'd3;

  // Follow-up actions after the first phase.
  localparam logic [1:0] FOLLOW_STOP     = 2'd0;
  localparam logic [1:0] FOLLOW_WRITE    = 2'd1;
  localparam logic [1:0] FOLLOW_RS_READ  = 2'd2;
  localparam logic [1:0] FOLLOW_RS_WRITE = 2'd3;

  // Input operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // Commands to the byte-level bus engine.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_RECV    = 2'd2,
    CMD_STOP    = 2'd3
  } bus_cmd_t;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0]  slave_address;
    logic [15:0] first_length;
    logic [1:0]  follow_mode;
    logic [15:0] second_length;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic       operation;
    logic       start_read;
    logic       slave_nacked;
    logic       arb_lost;
    logic       bus_fault;
    logic [7:0] received_byte;
    logic [7:0] next_tx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       accepted;
    bus_cmd_t   bus_command;
    logic       send_nack;
    logic       addr_write;
    logic [7:0] addr_byte;
    logic       data_write;
    logic [7:0] data_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       flush_engine;
    logic       done_res;
    logic       error;
  } result_t;

endpackage

// File: sv/i2cmts_cfg.sv
// Configuration register file of the I2C master transaction sequencer.
module i2cmts_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output i2cmts_pkg::cfg_t    cfg
);

  i2cmts_pkg::cfg_t cfg_r;

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address <= 7'd0;
      cfg_r.first_length  <= 16'd1;
      cfg_r.follow_mode   <= i2cmts_pkg::FOLLOW_STOP;
      cfg_r.second_length <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmts_pkg::REG_SLAVE_ADDRESS: cfg_r.slave_address <= cfg_data[6:0];
        i2cmts_pkg::REG_FIRST_LENGTH:  cfg_r.first_length  <= cfg_data;
        i2cmts_pkg::REG_FOLLOW_MODE:   cfg_r.follow_mode   <= cfg_data[1:0];
        i2cmts_pkg::REG_SECOND_LENGTH: cfg_r.second_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/i2cmts_fsm.sv
// Transaction state machine: applies one item to the sequencer state.
module i2cmts_fsm #(
  parameter int unsigned LEN_BITS = i2cmts_pkg::LEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  i2cmts_pkg::item_t     item,
  input  i2cmts_pkg::cfg_t      cfg,
  output i2cmts_pkg::result_t   res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TX     = 4'd1,
    PH_RX     = 4'd2,
    PH_TXDONE = 4'd3,
    PH_PARKED = 4'd4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                follow_pending_r, follow_pending_nxt;
  logic                address_check_r, address_check_nxt;
  logic                busy_r, busy_nxt;
  logic                error_r, error_nxt;

  // Lengths brought to the counter width.
  logic [31:0]         first_ext, second_ext;
  logic [LEN_BITS-1:0] first_len, second_len;
  logic [LEN_BITS-1:0] send_base, send_cnt, rx_cnt;
  logic                follow_rs;

  assign first_ext  = {16'd0, cfg.first_length};
  assign second_ext = {16'd0, cfg.second_length};
  assign first_len  = first_ext[LEN_BITS-1:0];
  assign second_len = second_ext[LEN_BITS-1:0];

  // A write that continues into the second phase reloads the count first.
  assign send_base = (phase_r == PH_TXDONE) ? second_len : bytes_left_r;
  assign send_cnt  = send_base - LEN_BITS'(1);
  assign rx_cnt    = bytes_left_r - LEN_BITS'(1);
  assign follow_rs = follow_pending_r &&
                     ((cfg.follow_mode == i2cmts_pkg::FOLLOW_RS_READ) ||
                      (cfg.follow_mode == i2cmts_pkg::FOLLOW_RS_WRITE));

  // Next state and result for the item in hand.
  always_comb begin
    phase_nxt          = phase_r;
    bytes_left_nxt     = bytes_left_r;
    follow_pending_nxt = follow_pending_r;
    address_check_nxt  = address_check_r;
    busy_nxt           = busy_r;
    error_nxt          = error_r;
    res                = '0;
    res.bus_command    = i2cmts_pkg::CMD_NONE;

    if (item.operation == i2cmts_pkg::OP_START) begin
      // Start request: only taken while not busy.
      if (!busy_r) begin
        busy_nxt           = 1'b1;
        res.accepted       = 1'b1;
        address_check_nxt  = 1'b1;
        follow_pending_nxt = 1'b1;
        bytes_left_nxt     = first_len;
        res.addr_write     = 1'b1;
        res.addr_byte      = {cfg.slave_address, item.start_read};
        phase_nxt          = item.start_read ? PH_RX : PH_TX;
      end
    end else if (item.bus_fault) begin
      res.flush_engine = 1'b1;
      error_nxt        = 1'b1;
      busy_nxt         = 1'b0;
      phase_nxt        = PH_PARKED;
    end else if (item.arb_lost || (address_check_r && item.slave_nacked)) begin
      error_nxt = 1'b1;
      busy_nxt  = 1'b0;
      phase_nxt = PH_PARKED;
    end else begin
      case (phase_r)
        PH_TX, PH_TXDONE: begin
          if (item.slave_nacked || (phase_r == PH_TXDONE &&
              (!follow_pending_r || cfg.follow_mode == i2cmts_pkg::FOLLOW_STOP))) begin
            // Data NACK or end of transfer: plain stop.
            res.bus_command = i2cmts_pkg::CMD_STOP;
            error_nxt       = 1'b0;
            busy_nxt        = 1'b0;
            phase_nxt       = PH_IDLE;
          end else if (phase_r == PH_TX ||
                       cfg.follow_mode == i2cmts_pkg::FOLLOW_WRITE) begin
            // Transmit the next byte.
            if (phase_r == PH_TXDONE) follow_pending_nxt = 1'b0;
            address_check_nxt = 1'b0;
            res.data_write    = 1'b1;
            res.data_byte     = item.next_tx_byte;
            bytes_left_nxt    = send_cnt;
            phase_nxt         = (send_cnt != '0) ? PH_TX : PH_TXDONE;
          end else begin
            // Repeated start into the second phase.
            address_check_nxt  = 1'b1;
            res.bus_command    = i2cmts_pkg::CMD_RESTART;
            res.send_nack      = 1'b1;
            res.addr_write     = 1'b1;
            res.addr_byte      = {cfg.slave_address, ~cfg.follow_mode[0]};
            bytes_left_nxt     = second_len;
            follow_pending_nxt = 1'b0;
            phase_nxt          = cfg.follow_mode[0] ? PH_TX : PH_RX;
          end
        end
        PH_RX: begin
          address_check_nxt = 1'b0;
          res.rx_valid      = 1'b1;
          res.rx_data       = item.received_byte;
          bytes_left_nxt    = rx_cnt;
          if (rx_cnt != '0) begin
            res.bus_command = i2cmts_pkg::CMD_RECV;
          end else if (follow_rs) begin
            address_check_nxt  = 1'b1;
            res.bus_command    = i2cmts_pkg::CMD_RESTART;
            res.send_nack      = 1'b1;
            res.addr_write     = 1'b1;
            res.addr_byte      = {cfg.slave_address, ~cfg.follow_mode[0]};
            bytes_left_nxt     = second_len;
            follow_pending_nxt = 1'b0;
            phase_nxt          = cfg.follow_mode[0] ? PH_TX : PH_RX;
          end else begin
            // Last byte read: NACK it and stop.
            res.bus_command = i2cmts_pkg::CMD_STOP;
            res.send_nack   = 1'b1;
            error_nxt       = 1'b0;
            busy_nxt        = 1'b0;
            phase_nxt       = PH_IDLE;
          end
        end
        PH_PARKED: begin
          busy_nxt = 1'b0;
        end
        default: begin
          error_nxt = 1'b0;
          busy_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    res.done_res = busy_r && !busy_nxt;
    res.error    = error_nxt;
  end

  // Sequencer state, updated once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      bytes_left_r     <= '0;
      follow_pending_r <= 1'b0;
      address_check_r  <= 1'b0;
      busy_r           <= 1'b0;
      error_r          <= 1'b0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      bytes_left_r     <= bytes_left_nxt;
      follow_pending_r <= follow_pending_nxt;
      address_check_r  <= address_check_nxt;
      busy_r           <= busy_nxt;
      error_r          <= error_nxt;
    end
  end

endmodule

// File: sv/i2c_master_transaction_sequencer.sv
// Top level of the I2C master transaction sequencer.
//
// Usage: each input transfer is either a start request or a bus engine
// event; each one yields exactly one result transfer carrying the bus
// command, address or data byte to issue, any received byte to store, and
// the busy-to-idle and sticky error flags. The user must write the config
// registers (slave address, phase lengths, follow-up mode) via cfg_we,
// cfg_index, cfg_data only while no transfer is in flight (not enforced).
// Timing: an accepted input is captured in an input register, applied to
// the state machine once the output register is free or being read, and
// its result is then presented from the output register.
// Throughput: one item per cycle while the receiver keeps out_ready high.
// If the receiver stalls, the result is held in the output register, one
// more item may wait in the input register, and then in_ready drops.
// Reset (synchronous, rst_n low) empties both registers, returns the
// sequencer to idle with no error, and loads the register defaults.
module i2c_master_transaction_sequencer #(
  parameter int unsigned LEN_BITS = i2cmts_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_start_read,
  input  logic        in_slave_nacked,
  input  logic        in_arb_lost,
  input  logic        in_bus_fault,
  input  logic [7:0]  in_received_byte,
  input  logic [7:0]  in_next_tx_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_bus_command,
  output logic        out_send_nack,
  output logic        out_addr_write,
  output logic [7:0]  out_addr_byte,
  output logic        out_data_write,
  output logic [7:0]  out_data_byte,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_data,
  output logic        out_flush_engine,
  output logic        out_done_res,
  output logic        out_error
);

  i2cmts_pkg::cfg_t    cfg;
  i2cmts_pkg::item_t   item_r;
  i2cmts_pkg::result_t step_res, res_r;
  logic                item_valid_r, out_valid_r;
  logic                in_fire, step_fire;

  i2cmts_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake between the input register, the state machine and the output.
  assign step_fire = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || step_fire;
  assign in_fire   = in_valid && in_ready;

  i2cmts_fsm #(
    .LEN_BITS (LEN_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // Valid flags of the input and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) item_valid_r <= 1'b1;
      else if (step_fire) item_valid_r <= 1'b0;
      if (step_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.operation     <= in_operation;
      item_r.start_read    <= in_start_read;
      item_r.slave_nacked  <= in_slave_nacked;
      item_r.arb_lost      <= in_arb_lost;
      item_r.bus_fault     <= in_bus_fault;
      item_r.received_byte <= in_received_byte;
      item_r.next_tx_byte  <= in_next_tx_byte;
    end
    if (step_fire) res_r <= step_res;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = res_r.accepted;
  assign out_bus_command  = res_r.bus_command;
  assign out_send_nack    = res_r.send_nack;
  assign out_addr_write   = res_r.addr_write;
  assign out_addr_byte    = res_r.addr_byte;
  assign out_data_write   = res_r.data_write;
  assign out_data_byte    = res_r.data_byte;
  assign out_rx_valid     = res_r.rx_valid;
  assign out_rx_data      = res_r.rx_data;
  assign out_flush_engine = res_r.flush_engine;
  assign out_done_res     = res_r.done_res;
  assign out_error        = res_r.error;

endmodule
